@@ src/sse_pkg.sv @@
// Shared types and constants of the subset-sum enumerator.
package sse_pkg;

  localparam int TARGET_W = 20;
  localparam int COUNT_W  = 5;
  localparam int INDEX_W  = 4;
  localparam int VALUE_W  = 16;
  localparam int MASK_W   = 16;
  localparam int SUM_W    = 21;
  localparam int CFG_W    = 20;
  localparam int REG_IDX_W = 1;

  localparam logic [REG_IDX_W-1:0] REG_TARGET = 1'b0;
  localparam logic [REG_IDX_W-1:0] REG_COUNT  = 1'b1;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_NEXT = 1'b1;

  typedef enum logic [0:0] {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_t;

  typedef struct packed {
    logic             fits;
    logic             hit;
    logic [SUM_W-1:0] value;
  } alu_res_t;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_CHECK  = 6'b000010,
    ST_TEST   = 6'b000100,
    ST_SCAN   = 6'b001000,
    ST_DROP   = 6'b010000,
    ST_RESULT = 6'b100000
  } state_t;

endpackage

@@ src/sse_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module sse_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ src/sse_alu.sv @@
// Shared add/subtract and compare unit for the running sum.
module sse_alu
  import sse_pkg::*;
(
  input  alu_op_t             op,
  input  logic [SUM_W-1:0]    sum,
  input  logic [VALUE_W-1:0]  elem,
  input  logic [TARGET_W-1:0] target,
  output alu_res_t            res
);

  logic [SUM_W-1:0] operand;
  logic [SUM_W-1:0] value;

  // One adder serves both directions: subtraction adds the inverted operand plus one.
  assign operand = (op == ALU_SUB) ? ~SUM_W'(elem) : SUM_W'(elem);
  assign value   = sum + operand + SUM_W'(op == ALU_SUB);

  assign res.value = value;
  assign res.fits  = (value <= SUM_W'(target));
  assign res.hit   = (value == SUM_W'(target));

endmodule

@@ src/subset_sum_enumerator_unit.sv @@
// Top level of the subset-sum enumerator: sequencer, search state and result register.
//
// Usage: a request on the in_ channel is either a load (in_tuser = 0), which
// writes elem_value into the element store at elem_index and restarts the
// search, or a next request (in_tuser = 1), which resumes the depth-first
// backtracking search and produces exactly one result on the out_ channel.
// A load produces no result. The result carries the include mask of the next
// subset whose sum equals target_total (found = 1), or found = 0 and
// search_done = 1 once the whole tree has been walked.
// Registers target_total (index 0) and element_count (index 1) are written
// through cfg_we/cfg_index/cfg_wdata; each write also restarts the search.
// Throughput: one request at a time. A next request walks the search in steps:
// each tried inclusion reads the store and then adds and compares, and
// backtracking examines positions one by one, drops elements and passes the
// last element, with entry and result hand-off around the walk. The speed is
// set by the single store read port and the single shared adder, used once
// per search step. A finished result sits in the output register; the next
// request is already accepted while it waits. If out_tready stays low, the
// following result is held inside until the register frees up, and no new
// request is taken. Reset clears the registers, the search state and the
// output valid; the store contents stay undefined until loaded.
module subset_sum_enumerator_unit
  import sse_pkg::*;
#(
  parameter int MAX_ELEMENTS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // Request channel.
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [23:0]          in_tdata,   // [3:0] elem_index, [19:4] elem_value, rest zero
  input  logic [0:0]           in_tuser,   // [0] kind
  // Result channel.
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [15:0]          out_tdata,  // [15:0] subset_mask
  output logic [1:0]           out_tuser,  // [0] found, [1] search_done
  // Configuration write port.
  input  logic                 cfg_we,
  input  logic [REG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  localparam int IW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
  localparam int CW = $clog2(MAX_ELEMENTS + 1);

  state_t                  state_r, state_nxt;
  logic [TARGET_W-1:0]     target_r, target_nxt;
  logic [COUNT_W-1:0]      count_r, count_nxt;
  logic [MAX_ELEMENTS-1:0] flags_r, flags_nxt;
  logic [CW-1:0]           pos_r, pos_nxt;
  logic [SUM_W-1:0]        sum_r, sum_nxt;
  logic                    finished_r, finished_nxt;
  logic [IW-1:0]           k_r, k_nxt;
  logic                    res_found_r, res_found_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [MASK_W-1:0]       out_mask_r, out_mask_nxt;
  logic                    out_found_r, out_found_nxt;
  logic                    out_done_r, out_done_nxt;

  logic [CW-1:0]      active_n;
  logic               in_fire;
  logic               in_kind;
  logic [INDEX_W-1:0] in_idx;
  logic [VALUE_W-1:0] in_value;
  logic               store_we;
  logic [IW-1:0]      store_raddr;
  logic [VALUE_W-1:0] store_rdata;
  alu_op_t            alu_op;
  alu_res_t           alu_res;

  assign in_kind  = in_tuser[0];
  assign in_idx   = in_tdata[INDEX_W-1:0];
  assign in_value = in_tdata[INDEX_W+VALUE_W-1:INDEX_W];

  assign in_tready = (state_r == ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;

  // Number of elements searched: the count register saturated at the store size.
  assign active_n = (32'(count_r) > MAX_ELEMENTS) ? CW'(MAX_ELEMENTS) : CW'(count_r);

  // Loads beyond the store are dropped but still restart the search.
  assign store_we = in_fire && (in_kind == KIND_LOAD) && (32'(in_idx) < MAX_ELEMENTS);

  // The store is read at the current position when testing an inclusion,
  // and at the backtrack pointer otherwise.
  assign store_raddr = (state_r == ST_CHECK) ? pos_r[IW-1:0] : k_r;

  sse_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (MAX_ELEMENTS)
  ) u_store (
    .clk   (clk),
    .we    (store_we),
    .waddr (IW'(in_idx)),
    .wdata (in_value),
    .raddr (store_raddr),
    .rdata (store_rdata)
  );

  assign alu_op = (state_r == ST_DROP) ? ALU_SUB : ALU_ADD;

  sse_alu u_alu (
    .op     (alu_op),
    .sum    (sum_r),
    .elem   (store_rdata),
    .target (target_r),
    .res    (alu_res)
  );

  always_comb begin
    state_nxt     = state_r;
    target_nxt    = target_r;
    count_nxt     = count_r;
    flags_nxt     = flags_r;
    pos_nxt       = pos_r;
    sum_nxt       = sum_r;
    finished_nxt  = finished_r;
    k_nxt         = k_r;
    res_found_nxt = res_found_r;
    out_valid_nxt = out_valid_r;
    out_mask_nxt  = out_mask_r;
    out_found_nxt = out_found_r;
    out_done_nxt  = out_done_r;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    // Register writes must arrive only while idle; the block itself does not enforce it. Each one restarts the search.
    if (cfg_we) begin
      case (cfg_index)
        REG_TARGET: target_nxt = cfg_wdata[TARGET_W-1:0];
        REG_COUNT:  count_nxt  = cfg_wdata[COUNT_W-1:0];
        default:    target_nxt = target_r;
      endcase
      flags_nxt    = '0;
      pos_nxt      = '0;
      sum_nxt      = '0;
      finished_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_kind == KIND_LOAD) begin
            flags_nxt    = '0;
            pos_nxt      = '0;
            sum_nxt      = '0;
            finished_nxt = 1'b0;
          end else if (finished_r) begin
            res_found_nxt = 1'b0;
            state_nxt     = ST_RESULT;
          end else begin
            state_nxt = ST_CHECK;
          end
        end
      end
      ST_CHECK: begin
        if (pos_r < active_n) begin
          state_nxt = ST_TEST;
        end else if (active_n == '0) begin
          finished_nxt  = 1'b1;
          res_found_nxt = 1'b0;
          state_nxt     = ST_RESULT;
        end else begin
          // Past the last element: backtracking starts at the last element.
          k_nxt     = IW'(active_n - CW'(1));
          state_nxt = ST_SCAN;
        end
      end
      ST_TEST: begin
        if (alu_res.fits) begin
          flags_nxt[pos_r[IW-1:0]] = 1'b1;
          sum_nxt                  = alu_res.value;
          pos_nxt                  = pos_r + CW'(1);
          if (alu_res.hit) begin
            res_found_nxt = 1'b1;
            state_nxt     = ST_RESULT;
          end else begin
            state_nxt = ST_CHECK;
          end
        end else begin
          k_nxt     = pos_r[IW-1:0];
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        // Walk down one position a cycle to the highest included element.
        if (flags_r[k_r]) begin
          state_nxt = ST_DROP;
        end else if (k_r == '0) begin
          finished_nxt  = 1'b1;
          res_found_nxt = 1'b0;
          state_nxt     = ST_RESULT;
        end else begin
          k_nxt = k_r - IW'(1);
        end
      end
      ST_DROP: begin
        flags_nxt[k_r] = 1'b0;
        sum_nxt        = alu_res.value;
        pos_nxt        = CW'(k_r) + CW'(1);
        state_nxt      = ST_CHECK;
      end
      ST_RESULT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_mask_nxt  = res_found_r ? MASK_W'(flags_r) : '0;
          out_found_nxt = res_found_r;
          out_done_nxt  = !res_found_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      target_r    <= '0;
      count_r     <= '0;
      flags_r     <= '0;
      pos_r       <= '0;
      sum_r       <= '0;
      finished_r  <= 1'b0;
      k_r         <= '0;
      res_found_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      target_r    <= target_nxt;
      count_r     <= count_nxt;
      flags_r     <= flags_nxt;
      pos_r       <= pos_nxt;
      sum_r       <= sum_nxt;
      finished_r  <= finished_nxt;
      k_r         <= k_nxt;
      res_found_r <= res_found_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_mask_r  <= out_mask_nxt;
    out_found_r <= out_found_nxt;
    out_done_r  <= out_done_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_mask_r;
  assign out_tuser  = {out_done_r, out_found_r};

  // A result is either a match or the end of the search, never both or neither.
  a_result_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser[0] != out_tuser[1]))
    else $error("result is neither a single match nor a single done");

  // Only elements that keep the sum within the target are ever included.
  a_sum_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sum_r <= SUM_W'(target_r))
    else $error("running sum exceeds target");

  // The search position never runs past the active element count.
  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= active_n)
    else $error("search position beyond active elements");

  // A finished search has dropped every included element.
  a_done_empty: assert property (@(posedge clk) disable iff (!rst_n)
    finished_r |-> (flags_r == '0))
    else $error("finished search still holds included elements");

endmodule

@@ tb/subset_sum_enumerator_unit_tb.sv @@
// Self-checking testbench for the subset-sum enumerator: scoreboard class, stream drivers and checks.
module subset_sum_enumerator_unit_tb;
  import sse_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ELEMS = 16;
  // A load completes while the block stays idle, so a few idle cycles after the
  // last result are plenty before a register write.
  localparam int SETTLE_CYCLES = 8;
  // Length of the long receiver hold-off that fills the block up.
  localparam int LONG_HOLD = 600;
  localparam int RANDOM_REQUESTS = 1900;

  // Expected content of one result request.
  typedef struct packed {
    logic [MASK_W-1:0] mask;
    logic              found;
    logic              done;
  } subset_result_t;

  // The scoreboard keeps its own copy of the element store, the settings and
  // the search state, and walks the backtracking search itself for every next
  // request that the block accepts. Expected results wait in a queue.
  class subset_scoreboard;
    logic [VALUE_W-1:0]  store [ELEMS];
    logic [TARGET_W-1:0] target;
    logic [COUNT_W-1:0]  count;
    logic [MASK_W-1:0]   chosen;
    int unsigned         pos;
    int unsigned         total;
    bit                  exhausted;
    subset_result_t      pending_subsets [$];
    int                  errors;

    function new();
      target = '0;
      count  = '0;
      errors = 0;
      restart();
    endfunction

    function void restart();
      chosen    = '0;
      pos       = 0;
      total     = 0;
      exhausted = 1'b0;
    endfunction

    function int pending();
      return pending_subsets.size();
    endfunction

    function void write_reg(logic [REG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      case (idx)
        REG_TARGET: target = val[TARGET_W-1:0];
        REG_COUNT: count = val[COUNT_W-1:0];
        default: ;
      endcase
      restart();
    endfunction

    // Resumes the depth-first walk; returns 1 on the next exact match.
    function bit find_next_subset();
      int unsigned n;
      int          k;
      n = (count > ELEMS) ? ELEMS : count;
      while (!exhausted) begin
        if (pos < n && total + store[pos] <= target) begin
          chosen[pos] = 1'b1;
          total += store[pos];
          pos++;
          if (total == target) return 1'b1;
        end else begin
          // Past the end, backtracking starts at the last element.
          k = int'((pos >= n) ? n : pos + 1) - 1;
          while (k >= 0 && !chosen[k]) k--;
          if (k < 0) begin
            exhausted = 1'b1;
          end else begin
            chosen[k] = 1'b0;
            total -= store[k];
            pos = k + 1;
          end
        end
      end
      return 1'b0;
    endfunction

    function void note_request(logic kind, logic [INDEX_W-1:0] idx, logic [VALUE_W-1:0] val);
      subset_result_t res;
      if (kind == KIND_LOAD) begin
        store[idx] = val;
        restart();
      end else begin
        if (find_next_subset()) res = '{mask: chosen, found: 1'b1, done: 1'b0};
        else res = '{mask: '0, found: 1'b0, done: 1'b1};
        pending_subsets.push_back(res);
      end
    endfunction

    function void check_result(logic [MASK_W-1:0] mask, logic found, logic done);
      subset_result_t exp;
      if (pending_subsets.size() == 0) begin
        $display("%0t: result with none expected: mask %h found %b done %b",
                 $time, mask, found, done);
        errors++;
        return;
      end
      exp = pending_subsets.pop_front();
      if (mask !== exp.mask) begin
        $display("%0t: subset_mask expected %h got %h", $time, exp.mask, mask);
        errors++;
      end
      if (found !== exp.found) begin
        $display("%0t: found expected %b got %b", $time, exp.found, found);
        errors++;
      end
      if (done !== exp.done) begin
        $display("%0t: search_done expected %b got %b", $time, exp.done, done);
        errors++;
      end
    endfunction
  endclass

  // Every input of the block starts at a known value.
  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [23:0]          in_tdata = '0;    // [3:0] elem_index, [19:4] elem_value, rest zero
  logic [0:0]           in_tuser = '0;    // [0] kind
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [15:0]          out_tdata;        // [15:0] subset_mask
  logic [1:0]           out_tuser;        // [0] found, [1] search_done
  logic                 cfg_we = 1'b0;
  logic [REG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  subset_scoreboard sb = new();

  // Sender state: bursts of requests separated by idle gaps, switched off in
  // some phases so that back-to-back stretches occur as well.
  bit sender_gaps = 1'b1;
  int burst_left = 0;
  int requests_taken = 0;

  // The stimulus asks for a long receiver hold-off by bumping this counter;
  // the receiver process counts the hold-off cycles itself.
  int hold_requests = 0;

  subset_sum_enumerator_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Receiver: changes its stall rate every so often, from always ready to
  // mostly stalled, and serves the long hold-off when one is requested.
  int hold_served = 0;
  int hold_left = 0;
  int mode_left = 0;
  int stall_pct = 0;
  always @(posedge clk) begin
    if (hold_served != hold_requests) begin
      hold_served = hold_requests;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        mode_left = $urandom_range(20, 200);
        case ($urandom_range(0, 4))
          0, 1: stall_pct = 0;
          2: stall_pct = 25;
          3: stall_pct = 50;
          default: stall_pct = 90;
        endcase
      end
      mode_left--;
      out_tready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Result monitor. Values sampled here are the ones present at the edge,
  // since every driver updates through nonblocking assignments.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      sb.check_result(out_tdata, out_tuser[0], out_tuser[1]);
    end
  end

  // Offers one request and holds it until the block takes it. The valid is
  // left high afterwards so that the next request follows without a bubble.
  task automatic send_request(input logic kind, input logic [INDEX_W-1:0] idx,
                              input logic [VALUE_W-1:0] val);
    int gap;
    if (sender_gaps) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 12);
        gap = $urandom_range(1, 8);
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left--;
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {4'b0, val, idx};
    do @(posedge clk); while (!in_tready);
    sb.note_request(kind, idx, val);
    requests_taken++;
  endtask

  // Stops sending and waits until every expected result has come back, then
  // lets a load that may still be in flight finish.
  task automatic settle();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes both registers, the target and then the count, on consecutive edges. Only called while idle.
  task automatic write_settings(input logic [TARGET_W-1:0] goal,
                                input logic [COUNT_W-1:0] count);
    cfg_we    <= 1'b1;
    cfg_index <= REG_TARGET;
    cfg_wdata <= goal;
    @(posedge clk);
    sb.write_reg(REG_TARGET, goal);
    cfg_index <= REG_COUNT;
    cfg_wdata <= CFG_W'(count);
    @(posedge clk);
    sb.write_reg(REG_COUNT, CFG_W'(count));
    cfg_we <= 1'b0;
  endtask

  task automatic send_next();
    send_request(KIND_NEXT, INDEX_W'($urandom), VALUE_W'($urandom));
  endtask

  // Directed opening: fill the whole store with edge values, so that no later
  // search can read an entry that was never written, then walk known cases.
  task automatic directed_part();
    logic [VALUE_W-1:0] seed_vals [ELEMS] = '{
      16'd1, 16'd2, 16'd3, 16'hFFFF, 16'h0000, 16'hAAAA, 16'h5555, 16'h8000,
      16'h0001, 16'h7FFF, 16'h00FF, 16'hFF00, 16'h1234, 16'h0F0F, 16'hF0F0, 16'h0010};
    for (int i = 0; i < ELEMS; i++) send_request(KIND_LOAD, INDEX_W'(i), seed_vals[i]);
    // Reset settings: no elements take part, so the search ends at once.
    send_next();
    settle();
    // Elements 1, 2, 3 with target 3: {0,1}, then {2}, then done, and a
    // request after the end still reports done.
    write_settings(20'd3, 5'd3);
    repeat (4) send_next();
    settle();
    // Largest target that no subset reaches.
    write_settings(20'hFFFFF, 5'd3);
    send_next();
    settle();
    // Count above capacity with target zero: the empty subset never counts.
    write_settings(20'd0, 5'd31);
    send_next();
    settle();
    // A load in the middle of a search starts it over.
    write_settings(20'd3, 5'd3);
    send_next();
    send_request(KIND_LOAD, 4'd2, 16'd3);
    send_next();
  endtask

  // One random phase: pick settings and element values, load the elements,
  // then walk the search with next requests and a little load noise. Most
  // targets are sums of loaded elements so that matches actually occur.
  task automatic random_phase(input int phase_no);
    logic [VALUE_W-1:0]  vals [ELEMS];
    logic [TARGET_W-1:0] goal;
    logic [COUNT_W-1:0]  count;
    int                  n_eff;
    int                  top;
    int                  m;
    int                  pick;
    bit                  wide_phase;
    bit                  hold;
    settle();
    // A few phases search all 16 elements; their targets are sums of up to
    // three randomly picked loaded values.
    wide_phase = (phase_no % 20 == 7);
    hold = (phase_no == 3 || phase_no == 60);
    sender_gaps = (phase_no % 5 != 0) && !hold;
    burst_left = 0;
    if (wide_phase) begin
      count = $urandom_range(0, 1) ? COUNT_W'(ELEMS) : COUNT_W'($urandom_range(17, 31));
      n_eff = ELEMS;
      top = 65535;
    end else begin
      count = ($urandom_range(0, 15) == 0) ? '0 : COUNT_W'($urandom_range(1, 7));
      n_eff = count;
      case ($urandom_range(0, 3))
        0: top = 3;
        1: top = 15;
        2: top = 255;
        default: top = 65535;
      endcase
    end
    for (int i = 0; i < ELEMS; i++) begin
      vals[i] = VALUE_W'($urandom_range(0, top));
      if (top == 65535 && $urandom_range(0, 7) == 0) vals[i] = $urandom_range(0, 1) ? '1 : '0;
    end
    goal = '0;
    if (wide_phase) begin
      repeat (3) begin
        pick = $urandom_range(0, ELEMS - 1);
        if ($urandom_range(0, 1)) goal += vals[pick];
      end
    end else begin
      pick = $urandom_range(0, 15);
      if (pick == 0) goal = '0;
      else if (pick == 1) goal = '1;
      else if (pick < 4) goal = TARGET_W'($urandom_range(0, 20'hFFFFF));
      else for (int i = 0; i < n_eff; i++) if ($urandom_range(0, 1)) goal += vals[i];
    end
    write_settings(goal, count);
    // The hold-off starts while the sender keeps offering requests, so the
    // block fills its output and internal result and then refuses input.
    if (hold) hold_requests++;
    for (int i = 0; i < n_eff; i++) send_request(KIND_LOAD, INDEX_W'(i), vals[i]);
    m = hold ? 30 : $urandom_range(2, 20);
    repeat (m) begin
      if ($urandom_range(0, 11) == 0)
        send_request(KIND_LOAD, INDEX_W'($urandom_range(0, 15)), VALUE_W'($urandom));
      else
        send_next();
    end
  endtask

  initial begin : stimulus
    int base;
    int phase_no;
    int w;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    directed_part();
    base = requests_taken;
    phase_no = 0;
    while (requests_taken - base < RANDOM_REQUESTS) begin
      random_phase(phase_no);
      phase_no++;
    end
    in_tvalid <= 1'b0;
    for (w = 0; w < 200000 && sb.pending() != 0; w++) @(posedge clk);
    repeat (4 * SETTLE_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("TB_OK");
    end else begin
      if (sb.pending() != 0) $display("%0t: %0d results never arrived", $time, sb.pending());
      $display("TB_ERROR");
    end
    $finish;
  end

  // Watchdog far beyond the slowest legal run.
  initial begin : watchdog
    #50ms;
    $display("TB_ERROR");
    $finish;
  end

endmodule
